// ===== hw/rtl/tgn3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tgn3d_pkg;
  localparam int TableSizeDefault = 256;
  localparam int CoordFracBitsDefault = 16;
  localparam int GradWidth = 16;
  localparam int DotWidth = 36;
  localparam int NoiseWidth = 18;
  localparam int CellScale = 255;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef struct packed {
    logic signed [GradWidth-1:0] gx;
    logic signed [GradWidth-1:0] gy;
    logic signed [GradWidth-1:0] gz;
  } grad_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fz;
  } frac3_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tileable_gradient_noise_3d_top.sv =====
// Tileable 3D gradient noise, one octave.
// Input channel s_axis: tdata carries opcode, grad_index, grad_x, grad_y, grad_z,
// coord_x, coord_y, coord_z. A load item (opcode 0) writes one gradient table
// entry and gives no result. An evaluate item (opcode 1) gives one item of
// noise_value on m_axis, signed Q3.14, saturated.
// Every entry that an evaluation reads must be loaded first.
// The block is a pipeline of nine register stages: coordinate split, table read
// of eight replicated banks, products, dot sums with fade squares, fade, three
// blend levels and the output register. An item enters every cycle while the
// pipeline advances; its result is valid when it reaches the output register.
// The pipeline advances only while its last stage is empty or being taken, so
// a stall on m_axis holds every item in place and s_axis_tready falls.
// Reset empties the pipeline and holds s_axis_tready low; the gradient table
// keeps its contents and is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module tileable_gradient_noise_3d_top #(
  parameter int COORD_FRAC_BITS = tgn3d_pkg::CoordFracBitsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[0], grad_index[8:1], grad_x[24:9], grad_y[40:25], grad_z[56:41],
  // coord_x[72:57], coord_y[88:73], coord_z[104:89], zeros above
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // noise_value[17:0], zeros above
  output logic [23:0]       m_axis_tdata
);
  localparam int AW = $clog2(tgn3d_pkg::TableSizeDefault);
  localparam int DW = tgn3d_pkg::DotWidth;
  localparam int NS = 9;

  logic [NS-1:0] vld;
  logic adv;
  assign adv = !vld[NS-1] || m_axis_tready;
  assign s_axis_tready = adv && !rst;

  logic in_fire;
  tgn3d_pkg::opcode_t opc;
  tgn3d_pkg::grad_t wgrad;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign opc = tgn3d_pkg::opcode_t'(s_axis_tdata[0]);
  assign wgrad.gx = s_axis_tdata[24:9];
  assign wgrad.gy = s_axis_tdata[40:25];
  assign wgrad.gz = s_axis_tdata[56:41];

  // stage 1: split
  logic [7:0] cx, cy, cz;
  logic [15:0] fx, fy, fz;
  tgn3d_split #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_sx (
    .coord(s_axis_tdata[72:57]), .lattice_idx(cx), .frac(fx));
  tgn3d_split #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_sy (
    .coord(s_axis_tdata[88:73]), .lattice_idx(cy), .frac(fy));
  tgn3d_split #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_sz (
    .coord(s_axis_tdata[104:89]), .lattice_idx(cz), .frac(fz));

  logic [AW-1:0] sel1 [8];
  tgn3d_pkg::frac3_t f1;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        sel1[i] <= AW'((cx + 8'(i & 1)) ^ (cy + 8'((i >> 1) & 1))
                       ^ (cz + 8'((i >> 2) & 1)));
      end
      f1 <= '{fx: fx, fy: fy, fz: fz};
    end
  end

  // stage 2: table read, one bank per corner
  tgn3d_pkg::grad_t g2 [8];
  tgn3d_pkg::frac3_t f2;
  for (genvar b = 0; b < 8; b++) begin : g_bank
    tgn3d_pkg::grad_t mem [tgn3d_pkg::TableSizeDefault];
    always_ff @(posedge clk) begin
      if (in_fire && opc == tgn3d_pkg::OP_LOAD) begin
        mem[AW'(s_axis_tdata[8:1])] <= wgrad;
      end
      if (adv) begin
        g2[b] <= mem[sel1[b]];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f2 <= f1;
    end
  end

  // stage 3: products
  logic signed [33:0] px3 [8], py3 [8], pz3 [8];
  tgn3d_pkg::frac3_t f3;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        px3[i] <= g2[i].gx * ((i & 1) != 0 ? $signed({1'b0, f2.fx}) - 18'sd65536
                                          : $signed({1'b0, f2.fx}));
        py3[i] <= g2[i].gy * ((i & 2) != 0 ? $signed({1'b0, f2.fy}) - 18'sd65536
                                          : $signed({1'b0, f2.fy}));
        pz3[i] <= g2[i].gz * ((i & 4) != 0 ? $signed({1'b0, f2.fz}) - 18'sd65536
                                          : $signed({1'b0, f2.fz}));
      end
      f3 <= f2;
    end
  end

  // stage 4: dot sums, fade squares
  logic signed [DW-1:0] d4 [8];
  logic [15:0] sq4x, sq4y, sq4z;
  tgn3d_pkg::frac3_t f4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        d4[i] <= DW'(px3[i]) + DW'(py3[i]) + DW'(pz3[i]);
      end
      sq4x <= 16'((32'(f3.fx) * 32'(f3.fx)) >> 16);
      sq4y <= 16'((32'(f3.fy) * 32'(f3.fy)) >> 16);
      sq4z <= 16'((32'(f3.fz) * 32'(f3.fz)) >> 16);
      f4 <= f3;
    end
  end

  // stage 5: fade
  logic signed [DW-1:0] d5 [8];
  logic [15:0] u5, v5, w5;
  always_ff @(posedge clk) begin
    if (adv) begin
      d5 <= d4;
      u5 <= 16'((34'(sq4x) * (34'(196608) - 34'({f4.fx, 1'b0}))) >> 16);
      v5 <= 16'((34'(sq4y) * (34'(196608) - 34'({f4.fy, 1'b0}))) >> 16);
      w5 <= 16'((34'(sq4z) * (34'(196608) - 34'({f4.fz, 1'b0}))) >> 16);
    end
  end

  // stages 6-8: blend
  logic signed [DW-1:0] l6 [4];
  logic signed [DW-1:0] l7 [2];
  logic signed [DW-1:0] l8;
  logic [15:0] v6, w6, w7;
  for (genvar j = 0; j < 4; j++) begin : g_l1
    tgn3d_lerp u_l (.clk(clk), .en(adv), .a(d5[2*j]), .b(d5[2*j+1]), .u(u5),
                    .y(l6[j]));
  end
  for (genvar j = 0; j < 2; j++) begin : g_l2
    tgn3d_lerp u_l (.clk(clk), .en(adv), .a(l6[2*j]), .b(l6[2*j+1]), .u(v6),
                    .y(l7[j]));
  end
  tgn3d_lerp u_l3 (.clk(clk), .en(adv), .a(l7[0]), .b(l7[1]), .u(w7), .y(l8));
  always_ff @(posedge clk) begin
    if (adv) begin
      v6 <= v5;
      w6 <= w5;
      w7 <= w6;
    end
  end

  // stage 9: scale and saturate
  logic signed [DW-17:0] r8;
  logic [tgn3d_pkg::NoiseWidth-1:0] noise;
  assign r8 = l8[DW-1:16];
  always_ff @(posedge clk) begin
    if (adv) begin
      if (r8 > (DW-16)'(131071)) begin
        noise <= 18'h1FFFF;
      end else if (r8 < -(DW-16)'(131072)) begin
        noise <= 18'h20000;
      end else begin
        noise <= r8[17:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_fire && opc == tgn3d_pkg::OP_EVAL};
    end
  end

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata = {6'd0, noise};
endmodule
`default_nettype wire

// ===== hw/rtl/tgn3d_split.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tgn3d_split #(
  parameter int COORD_FRAC_BITS = tgn3d_pkg::CoordFracBitsDefault
) (
  input  wire logic [15:0] coord,
  output logic [7:0]       lattice_idx,
  output logic [15:0]      frac
);
  localparam int ProdW = COORD_FRAC_BITS + 8;
  logic [COORD_FRAC_BITS-1:0] c;
  logic [ProdW-1:0] s;
  logic [COORD_FRAC_BITS-1:0] fr;

  always_comb begin
    c = COORD_FRAC_BITS'(coord);
    s = (ProdW'(c) << 8) - ProdW'(c);
    fr = s[COORD_FRAC_BITS-1:0];
    lattice_idx = s[ProdW-1:COORD_FRAC_BITS];
    if (COORD_FRAC_BITS >= 16) begin
      frac = 16'(fr >> (COORD_FRAC_BITS - 16));
    end else begin
      frac = 16'({fr, 16'd0} >> COORD_FRAC_BITS);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tgn3d_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tgn3d_lerp (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic signed [tgn3d_pkg::DotWidth-1:0]  a,
  input  wire logic signed [tgn3d_pkg::DotWidth-1:0]  b,
  input  wire logic [15:0]                            u,
  output logic signed [tgn3d_pkg::DotWidth-1:0]       y
);
  localparam int W = tgn3d_pkg::DotWidth;
  logic signed [W:0] d;
  logic signed [W+17:0] p;

  always_comb begin
    d = (W+1)'(b) - (W+1)'(a);
    p = d * $signed({1'b0, u});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= W'(a + W'(p >>> 16));
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_tileable_gradient_noise_3d_top.sv =====
`timescale 1ns / 1ps
module tb_tileable_gradient_noise_3d_top;

  localparam int Latency = 9;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    tgn3d_pkg::opcode_t op;
    logic [7:0]  idx;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gz;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
  } noise_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  tileable_gradient_noise_3d_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  noise_req_t pending_reqs[$];
  logic signed [17:0] expected_noise[$];
  logic signed [15:0] grad_mem[256][3];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  longint cycle_count = 0;

  task automatic report_mismatch(input string what, input logic signed [17:0] got,
                                 input logic signed [17:0] want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic longint floor_div16(input longint v);
    return v >>> 16;
  endfunction

  function automatic longint smooth_fade(input longint f);
    longint f2;
    f2 = (f * f) >>> 16;
    return (f2 * (3 * 65536 - 2 * f)) >>> 16;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint u);
    return a + floor_div16((b - a) * u);
  endfunction

  function automatic logic signed [17:0] predict_noise(input noise_req_t r);
    longint cellv[3];
    longint fr[3];
    longint dots[8];
    longint s, acc, u, v, w, res;
    logic [7:0] sel;
    logic [15:0] c[3];
    c[0] = r.cx;
    c[1] = r.cy;
    c[2] = r.cz;
    for (int k = 0; k < 3; k++) begin
      s = longint'(c[k]) * tgn3d_pkg::CellScale;
      cellv[k] = s >> 16;
      fr[k] = s & 16'hFFFF;
    end
    for (int i = 0; i < 8; i++) begin
      sel = '0;
      acc = 0;
      for (int k = 0; k < 3; k++) sel ^= 8'(cellv[k] + ((i >> k) & 1));
      for (int k = 0; k < 3; k++)
        acc += longint'(grad_mem[sel][k]) * (fr[k] - ((i >> k) & 1) * 65536);
      dots[i] = acc;
    end
    u = smooth_fade(fr[0]);
    v = smooth_fade(fr[1]);
    w = smooth_fade(fr[2]);
    res = blend(blend(blend(dots[0], dots[1], u), blend(dots[2], dots[3], u), v),
                blend(blend(dots[4], dots[5], u), blend(dots[6], dots[7], u), v), w);
    res = floor_div16(res);
    if (res > 131071) res = 131071;
    if (res < -131072) res = -131072;
    return 18'(res);
  endfunction

  function automatic logic [111:0] pack_req(input noise_req_t r);
    return {7'b0, r.cz, r.cy, r.cx, r.gz, r.gy, r.gx, r.idx, r.op};
  endfunction

  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic push_load(input int idx, input logic [15:0] gx, input logic [15:0] gy,
                           input logic [15:0] gz);
    noise_req_t r;
    r = '0;
    r.op = tgn3d_pkg::OP_LOAD;
    r.idx = 8'(idx);
    r.gx = gx;
    r.gy = gy;
    r.gz = gz;
    r.cx = 16'($urandom);
    r.cy = 16'($urandom);
    r.cz = 16'($urandom);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic push_eval(input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] cz);
    noise_req_t r;
    r = '0;
    r.op = tgn3d_pkg::OP_EVAL;
    r.idx = 8'($urandom);
    r.gx = 16'($urandom);
    r.gy = 16'($urandom);
    r.gz = 16'($urandom);
    r.cx = cx;
    r.cy = cy;
    r.cz = cz;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_noise.size() != 0) @(posedge clk);
  endtask

  // Driver: the prediction is made at acceptance, so loads update the table in order.
  always @(posedge clk) begin
    noise_req_t r;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = pending_reqs.pop_front();
        if (r.op == tgn3d_pkg::OP_LOAD) begin
          grad_mem[r.idx][0] = r.gx;
          grad_mem[r.idx][1] = r.gy;
          grad_mem[r.idx][2] = r.gz;
        end else begin
          expected_noise = {expected_noise, predict_noise(r)};
        end
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pack_req(pending_reqs[0]);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    logic signed [17:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_noise.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[17:0], '0);
        end else begin
          want = expected_noise.pop_front();
          if (m_axis_tdata[17:0] !== want)
            report_mismatch("noise_value", m_axis_tdata[17:0], want);
          if (m_axis_tdata[23:18] !== '0)
            report_mismatch("padding", 18'(m_axis_tdata[23:18]), '0);
        end
      end
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout");
      $display("** tileable_gradient_noise_3d_top: FAILED **");
      $finish;
    end
  end

  // All table entries are loaded before any evaluation, so no unwritten entry is read.
  initial begin
    int ph;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 256; i++) begin
      case (i % 4)
        0: push_load(i, 16'sd16384, -16'sd16384, 16'sd16384);
        1: push_load(i, -16'sd16384, 16'sd16384, 16'hFFFF);
        2: push_load(i, 16'h8000, 16'h7FFF, 16'h0000);
        default: push_load(i, rand_grad(), rand_grad(), rand_grad());
      endcase
    end
    wait_drained();
    push_eval(16'h0000, 16'h0000, 16'h0000);
    push_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_eval(16'h8000, 16'h4000, 16'hC000);
    push_eval(16'h0101, 16'hFEFF, 16'h7FFF);
    push_eval(16'h0100, 16'h0101, 16'hFF00);
    push_eval(16'hFFFF, 16'h0000, 16'h5555);
    push_eval(16'hAAAA, 16'h5555, 16'hFFFF);
    push_load(0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_load(1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_eval(16'h0080, 16'h0080, 16'h0080);
    push_load(0, 16'h8000, 16'h8000, 16'h8000);
    push_eval(16'h00C0, 16'h0040, 16'h0080);
    wait_drained();
    // Long receiver hold-off while the sender keeps offering items.
    hold_off_cycles <= 300;
    for (int i = 0; i < 60; i++) push_eval(16'($urandom), 16'($urandom), 16'($urandom));
    wait_drained();
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 59; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 59; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 230; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_load($urandom_range(0, 255), rand_grad(), rand_grad(), rand_grad());
        else if ($urandom_range(0, 9) == 0)
          push_eval(16'($urandom_range(0, 7) * 257), 16'($urandom_range(65528, 65535)),
                    16'($urandom));
        else
          push_eval(16'($urandom), 16'($urandom), 16'($urandom));
      end
      wait_drained();
    end
    repeat (Latency + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("** tileable_gradient_noise_3d_top: PASSED **");
    end else begin
      $display("** tileable_gradient_noise_3d_top: FAILED **");
    end
    $finish;
  end
endmodule
